FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros pick up clk and rst_n from the module that uses them.

// Same-cycle implication.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/segenv_pkg.sv
package segenv_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int LEVEL_BITS_DEF   = 16;
  localparam int SLOPE_SHIFT      = 16;
  localparam int ADSR_SUSTAIN     = 2;

  localparam int CMD_W       = 3;
  localparam int IDX_W       = 4;
  localparam int DAC_W       = 16;
  localparam int COUNT_W     = 15;
  localparam int SEG_W       = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_SEG_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ADSR      = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   load_index;
    logic [DAC_W-1:0]   start_level;
    logic [DAC_W-1:0]   final_level;
    logic [COUNT_W-1:0] step_total;
    logic [COUNT_W-1:0] ticks_per_step;
  } in_word_t;

  typedef struct packed {
    logic               write_strobe;
    logic [DAC_W-1:0]   dac_value;
    logic [SEG_W-1:0]   active_segment;
    logic               finished;
    logic               end_event;
    logic               restarted;
  } out_word_t;

  // last-written store update
  typedef struct packed {
    logic set;
    logic clear;
  } lw_cmd_t;

endpackage

FILE: src/segment_envelope_generator.sv
// Tick: table read, slope multiply (ST_MUL), update (ST_UPD); next word taken after commit.
// Load to a valid index: waits in ST_DIV on the one-bit-a-cycle slope divider, then updates.
// Restart, release, stop, unused codes and out-of-range loads go straight to the update.
// Result is registered; the next word is taken while it waits, the update stalls until free.
// Synchronous active-low reset clears counters, pointer, flags and last-written levels at
// once and sets attack; segment table is undefined until loaded and has no clearing pass.
`include "assert_macros.svh"

module segment_envelope_generator
  import segenv_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int LEVEL_BITS   = LEVEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int LW = LEVEL_BITS;
  localparam int SW = LEVEL_BITS + SLOPE_SHIFT;
  localparam int MW = COUNT_W + SW;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_UPD} state_t;

  state_t             state_r;
  in_word_t           item_r;
  logic [LW-1:0]      prod_r;
  logic               out_valid_r;
  out_word_t          out_word_r;
  out_word_t          out_nxt;
  logic [COUNT_W-1:0] step_r, step_nxt;
  logic [COUNT_W-1:0] hold_r, hold_nxt;
  logic [SEG_W-1:0]   ptr_r, ptr_nxt;
  logic               stopped_r, stopped_nxt;
  logic               attack_r, attack_nxt;
  logic               endrep_r, endrep_nxt;
  logic [SEG_W-1:0]   seg_count_r;
  logic               repeat_r;
  logic               adsr_r;

  logic               commit;
  logic               load_ok_in;
  logic               load_ok;
  logic               div_start;
  logic               div_done;
  logic [SW-1:0]      div_q;
  logic [LW-1:0]      b_in, e_in, diff_in;
  logic [COUNT_W-1:0] st_in;
  logic [LW-1:0]      b_ld, e_ld;
  logic [COUNT_W-1:0] st_ld;

  logic [LW-1:0]      rd_start, rd_final, rd_lw;
  logic [COUNT_W-1:0] rd_steps, rd_hold;
  logic [SW-1:0]      rd_slope;
  logic               rd_falling;
  logic               seg_we;
  lw_cmd_t            lw_cmd, lw_cmd_g;
  logic [AW-1:0]      lw_waddr;

  logic [MW-1:0]      mult;
  logic [SEG_W-1:0]   lim_cur;
  logic [LW-1:0]      level;
  logic [COUNT_W-1:0] hold_eff;
  logic [COUNT_W:0]   hold_inc, step_inc;

  function automatic logic [SEG_W-1:0] seg_limit(input logic [SEG_W-1:0] cnt,
                                                 input logic adsr, input logic attack);
    logic [SEG_W-1:0] n;
    n = (int'(cnt) > MAX_SEGMENTS) ? SEG_W'(MAX_SEGMENTS) : cnt;
    if (adsr && attack && n > SEG_W'(ADSR_SUSTAIN)) begin
      n = SEG_W'(ADSR_SUSTAIN);
    end
    return n;
  endfunction

  // slope division is kicked off straight from the incoming word
  assign b_in       = LW'(in_data.start_level);
  assign e_in       = LW'(in_data.final_level);
  assign diff_in    = (e_in >= b_in) ? e_in - b_in : b_in - e_in;
  assign st_in      = (in_data.step_total == '0) ? COUNT_W'(1) : in_data.step_total;
  assign load_ok_in = int'(in_data.load_index) < MAX_SEGMENTS;
  assign in_ready   = (state_r == ST_IDLE);
  assign div_start  = in_ready && in_valid && in_data.command == CMD_LOAD && load_ok_in;

  segenv_div #(
    .DIVIDEND_W(SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({diff_in, {SLOPE_SHIFT{1'b0}}}),
    .divisor  (st_in),
    .done     (div_done),
    .quotient (div_q)
  );

  assign b_ld    = LW'(item_r.start_level);
  assign e_ld    = LW'(item_r.final_level);
  assign st_ld   = (item_r.step_total == '0) ? COUNT_W'(1) : item_r.step_total;
  assign load_ok = int'(item_r.load_index) < MAX_SEGMENTS;

  assign commit   = (state_r == ST_UPD) && (!out_valid_r || out_ready);
  assign lw_cmd_g = commit ? lw_cmd : '0;

  // Reads follow the pointer every cycle. Writes land only on the commit edge and the
  // next word is accepted only from ST_IDLE after it, so reads never see stale data.
  segenv_store #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_addr    (AW'(ptr_r)),
    .seg_we     (seg_we && commit),
    .seg_waddr  (AW'(item_r.load_index)),
    .wr_start   (b_ld),
    .wr_final   (e_ld),
    .wr_steps   (st_ld),
    .wr_hold    (item_r.ticks_per_step),
    .wr_slope   (div_q),
    .wr_falling (e_ld < b_ld),
    .rd_start   (rd_start),
    .rd_final   (rd_final),
    .rd_steps   (rd_steps),
    .rd_hold    (rd_hold),
    .rd_slope   (rd_slope),
    .rd_falling (rd_falling),
    .lw_cmd     (lw_cmd_g),
    .lw_waddr   (lw_waddr),
    .lw_wdata   (level),
    .lw_rdata   (rd_lw)
  );

  assign mult     = MW'(step_r) * MW'(rd_slope);
  assign lim_cur  = seg_limit(seg_count_r, adsr_r, attack_r);
  assign hold_eff = (rd_hold == '0) ? COUNT_W'(1) : rd_hold;
  assign hold_inc = {1'b0, hold_r} + (COUNT_W+1)'(1);
  assign step_inc = {1'b0, step_r} + (COUNT_W+1)'(1);

  always_comb begin
    if (step_r >= rd_steps) begin
      level = rd_final;
    end else if (rd_falling) begin
      level = rd_start - prod_r;
    end else begin
      level = rd_start + prod_r;
    end
  end

  always_comb begin
    step_nxt    = step_r;
    hold_nxt    = hold_r;
    ptr_nxt     = ptr_r;
    stopped_nxt = stopped_r;
    attack_nxt  = attack_r;
    endrep_nxt  = endrep_r;
    out_nxt     = '0;
    seg_we      = 1'b0;
    lw_cmd      = '0;
    lw_waddr    = AW'(ptr_r);

    case (item_r.command)
      CMD_TICK: begin
        if (!stopped_r) begin
          if (ptr_r < lim_cur) begin
            out_nxt.write_strobe = (level != rd_lw);
            out_nxt.dac_value    = DAC_W'(level);
            if (hold_inc >= {1'b0, hold_eff}) begin
              hold_nxt = '0;
              if (step_inc >= {1'b0, rd_steps}) begin
                step_nxt     = '0;
                ptr_nxt      = ptr_r + SEG_W'(1);
                lw_cmd.clear = 1'b1;
              end else begin
                step_nxt   = step_inc[COUNT_W-1:0];
                lw_cmd.set = 1'b1;
              end
            end else begin
              hold_nxt   = hold_inc[COUNT_W-1:0];
              lw_cmd.set = 1'b1;
            end
          end
          if (ptr_nxt >= lim_cur) begin
            out_nxt.finished = 1'b1;
            if (repeat_r) begin
              step_nxt          = '0;
              hold_nxt          = '0;
              ptr_nxt           = '0;
              stopped_nxt       = 1'b0;
              endrep_nxt        = 1'b0;
              attack_nxt        = 1'b1;
              out_nxt.restarted = 1'b1;
            end else if (!endrep_r && !(adsr_r && attack_r)) begin
              endrep_nxt        = 1'b1;
              out_nxt.end_event = 1'b1;
            end
          end
        end
      end
      CMD_LOAD: begin
        if (load_ok) begin
          seg_we       = 1'b1;
          lw_cmd.clear = 1'b1;
          lw_waddr     = AW'(item_r.load_index);
          if ({1'b0, item_r.load_index} == ptr_r) begin
            step_nxt = '0;
            hold_nxt = '0;
          end
        end
      end
      CMD_RESTART: begin
        step_nxt          = '0;
        hold_nxt          = '0;
        ptr_nxt           = '0;
        stopped_nxt       = 1'b0;
        endrep_nxt        = 1'b0;
        attack_nxt        = 1'b1;
        out_nxt.restarted = 1'b1;
      end
      CMD_RELEASE: attack_nxt  = 1'b0;
      CMD_STOP:    stopped_nxt = 1'b1;
      default: ;
    endcase

    if (item_r.command != CMD_TICK) begin
      out_nxt.finished = ptr_nxt >= seg_limit(seg_count_r, adsr_r, attack_nxt);
    end
    out_nxt.active_segment = ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      hold_r      <= '0;
      ptr_r       <= '0;
      stopped_r   <= 1'b0;
      attack_r    <= 1'b1;
      endrep_r    <= 1'b0;
      seg_count_r <= '0;
      repeat_r    <= 1'b0;
      adsr_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEG_COUNT: seg_count_r <= cfg_wdata[SEG_W-1:0];
          REG_REPEAT:    repeat_r    <= cfg_wdata[0];
          REG_ADSR:      adsr_r      <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            if (in_data.command == CMD_TICK) begin
              state_r <= ST_MUL;
            end else if (div_start) begin
              state_r <= ST_DIV;
            end else begin
              state_r <= ST_UPD;
            end
          end
        end
        ST_MUL: begin
          prod_r  <= mult[SLOPE_SHIFT +: LW];
          state_r <= ST_UPD;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (commit) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_word_r  <= out_nxt;
            step_r      <= step_nxt;
            hold_r      <= hold_nxt;
            ptr_r       <= ptr_nxt;
            stopped_r   <= stopped_nxt;
            attack_r    <= attack_nxt;
            endrep_r    <= endrep_nxt;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  `CHK_NEXT(a_one_word, in_valid && in_ready, !in_ready, "second word taken mid-update")
  `CHK_IMPL(a_div_state, div_done, state_r == ST_DIV, "divide finished outside load")
  `CHK_IMPL(a_end_fin, out_valid && out_data.end_event, out_data.finished, "end without finish")
  `CHK_IMPL(a_restart_clean, out_valid && out_data.restarted, out_data.active_segment == '0 && !out_data.end_event, "restart left pointer or end pulse")

endmodule

FILE: src/segenv_div.sv
`include "assert_macros.svh"

module segenv_div
  import segenv_pkg::*;
#(
  parameter int DIVIDEND_W = LEVEL_BITS_DEF + SLOPE_SHIFT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [COUNT_W-1:0]    divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [COUNT_W-1:0]    rem_r;
  logic [COUNT_W-1:0]    div_r;
  logic [DIVIDEND_W-1:0] dq_r;     // dividend shifts out, quotient shifts in

  logic [COUNT_W:0] trial;
  logic [COUNT_W:0] trial_sub;
  logic             ge;

  assign trial     = {rem_r, dq_r[DIVIDEND_W-1]};
  assign ge        = trial >= {1'b0, div_r};
  assign trial_sub = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      dq_r  <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
      dq_r  <= {dq_r[DIVIDEND_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

  `CHK_IMPL(a_start_idle, start, !busy_r, "divide started while busy")

endmodule

FILE: src/segenv_store.sv
module segenv_store
  import segenv_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int LEVEL_BITS   = LEVEL_BITS_DEF,
  localparam int AW = $clog2(MAX_SEGMENTS),
  localparam int LW = LEVEL_BITS,
  localparam int SW = LEVEL_BITS + SLOPE_SHIFT
) (
  input  logic               clk,
  input  logic               rst_n,
  // both stores are read at the same address every cycle
  input  logic [AW-1:0]      rd_addr,
  input  logic               seg_we,
  input  logic [AW-1:0]      seg_waddr,
  input  logic [LW-1:0]      wr_start,
  input  logic [LW-1:0]      wr_final,
  input  logic [COUNT_W-1:0] wr_steps,
  input  logic [COUNT_W-1:0] wr_hold,
  input  logic [SW-1:0]      wr_slope,
  input  logic               wr_falling,
  output logic [LW-1:0]      rd_start,
  output logic [LW-1:0]      rd_final,
  output logic [COUNT_W-1:0] rd_steps,
  output logic [COUNT_W-1:0] rd_hold,
  output logic [SW-1:0]      rd_slope,
  output logic               rd_falling,
  input  lw_cmd_t            lw_cmd,
  input  logic [AW-1:0]      lw_waddr,
  input  logic [LW-1:0]      lw_wdata,
  output logic [LW-1:0]      lw_rdata
);

  typedef struct packed {
    logic [LW-1:0]      start_lvl;
    logic [LW-1:0]      fin_lvl;
    logic [COUNT_W-1:0] steps;
    logic [COUNT_W-1:0] hold;
    logic [SW-1:0]      slope;
    logic               falling;
  } entry_t;

  entry_t            seg_mem [MAX_SEGMENTS];
  entry_t            seg_q_r;
  logic [LW-1:0]     lw_mem [MAX_SEGMENTS];
  logic [LW-1:0]     lw_q_r;
  logic [MAX_SEGMENTS-1:0] lw_vld_r;
  logic              lw_vq_r;

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[seg_waddr] <= '{start_lvl: wr_start, fin_lvl: wr_final, steps: wr_steps,
                              hold: wr_hold, slope: wr_slope, falling: wr_falling};
    end
    seg_q_r <= seg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lw_cmd.set) begin
      lw_mem[lw_waddr] <= lw_wdata;
    end
    lw_q_r <= lw_mem[rd_addr];
  end

  // an entry without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_vld_r <= '0;
      lw_vq_r  <= 1'b0;
    end else begin
      if (lw_cmd.set) begin
        lw_vld_r[lw_waddr] <= 1'b1;
      end else if (lw_cmd.clear) begin
        lw_vld_r[lw_waddr] <= 1'b0;
      end
      lw_vq_r <= lw_vld_r[rd_addr];
    end
  end

  assign rd_start   = seg_q_r.start_lvl;
  assign rd_final   = seg_q_r.fin_lvl;
  assign rd_steps   = seg_q_r.steps;
  assign rd_hold    = seg_q_r.hold;
  assign rd_slope   = seg_q_r.slope;
  assign rd_falling = seg_q_r.falling;
  assign lw_rdata   = lw_vq_r ? lw_q_r : '0;

endmodule
